@@ rtl/core/line_alignment_offset_defines.svh @@
// assertion macros shared by the checker
`ifndef LINE_ALIGNMENT_OFFSET_DEFINES_SVH
`define LINE_ALIGNMENT_OFFSET_DEFINES_SVH

// same-cycle implication, held off during reset
`define LAO_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define LAO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lao_pkg.sv @@
package lao_pkg;

    // field and datapath widths
    localparam int IN_W       = 24;
    localparam int DIF_W      = 25;
    localparam int SUM_W      = 26;
    localparam int ANG_W      = 25;
    localparam int FOLD_W     = 27;
    localparam int VEC_W      = 48;
    localparam int VEC_SHIFT  = 20;
    localparam int ROT_W      = 37;
    localparam int ROT_SHIFT  = 8;
    localparam int MUL_SPLIT  = 18;
    localparam int PP_W       = 44;
    localparam int PROD_W     = 62;
    localparam int GAIN_SHIFT = 24;
    localparam int GR_W       = 38;
    localparam int FIN_W      = 40;
    localparam int ANG_OUT_W  = 16;

    // parameter defaults
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_BITS_DEF   = 24;

    // angles in degrees, 16 fraction bits
    localparam logic signed [FOLD_W-1:0] DEG90  = FOLD_W'(90 * 65536);
    localparam logic signed [FOLD_W-1:0] DEG180 = FOLD_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0]  ANG_RND = ANG_W'(128);

    // cordic gain correction, 24 fraction bits
    localparam logic signed [24:0] GAIN_Q24 = 25'sd10188014;

    typedef logic signed [ANG_W-1:0] t_ang;
    typedef logic signed [SUM_W-1:0] t_sum;

    // sideband beside the vectoring pipe
    typedef struct packed {
        t_sum cx;
        t_sum cy;
        t_sum vx;
        t_sum vy;
    } t_sb_vec;

    // sideband beside the rotation pipe and the gain stages
    typedef struct packed {
        t_sum cx;
        t_sum cy;
        t_ang s;
    } t_sb_rot;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic t_ang atan_q16(input int i);
        t_ang r;
        case (i)
            0:       r = 25'sd2949120;
            1:       r = 25'sd1740967;
            2:       r = 25'sd919879;
            3:       r = 25'sd466945;
            4:       r = 25'sd234379;
            5:       r = 25'sd117304;
            6:       r = 25'sd58666;
            7:       r = 25'sd29335;
            8:       r = 25'sd14668;
            9:       r = 25'sd7334;
            10:      r = 25'sd3667;
            11:      r = 25'sd1833;
            12:      r = 25'sd917;
            13:      r = 25'sd458;
            14:      r = 25'sd229;
            15:      r = 25'sd115;
            16:      r = 25'sd57;
            17:      r = 25'sd29;
            18:      r = 25'sd14;
            19:      r = 25'sd7;
            20:      r = 25'sd4;
            21:      r = 25'sd2;
            22:      r = 25'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/lao_vec.sv @@
module lao_vec import lao_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [DIF_W-1:0] i_dx,
    input  logic signed [DIF_W-1:0] i_dy,
    output logic                    o_valid,
    output t_ang                    o_z
);

    logic signed [VEC_W-1:0] r_x [0:STEPS];
    logic signed [VEC_W-1:0] r_y [0:STEPS];
    t_ang                    r_z [0:STEPS];
    logic [STEPS:0]          r_zero;
    logic [STEPS:0]          r_v;

    logic signed [VEC_W-1:0] n_x, n_y, sx, sy;
    t_ang                    n_z;

    // scale and turn left-half-plane vectors into the right half
    always_comb begin
        sx = VEC_W'(i_dx) <<< VEC_SHIFT;
        sy = VEC_W'(i_dy) <<< VEC_SHIFT;
        n_x = sx;
        n_y = sy;
        n_z = '0;
        if (sx < 0) begin
            if (sy >= 0) begin
                n_x = sy;
                n_y = -sx;
                n_z = ANG_W'(DEG90);
            end else begin
                n_x = -sy;
                n_y = sx;
                n_z = -ANG_W'(DEG90);
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_dx == '0) && (i_dy == '0);
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [VEC_W-1:0] xs, ys;
        always_comb begin
            xs = r_x[k] >>> k;
            ys = r_y[k] >>> k;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] >= 0) begin
                    r_x[k+1] <= r_x[k] + ys;
                    r_y[k+1] <= r_y[k] - xs;
                    r_z[k+1] <= r_z[k] + atan_q16(k);
                end else begin
                    r_x[k+1] <= r_x[k] - ys;
                    r_y[k+1] <= r_y[k] + xs;
                    r_z[k+1] <= r_z[k] - atan_q16(k);
                end
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // zero-length segment points at 0 degrees
    assign o_z     = r_zero[STEPS] ? '0 : r_z[STEPS];
    assign o_valid = r_v[STEPS];

endmodule

@@ rtl/core/lao_rot.sv @@
module lao_rot import lao_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_sum                    i_vx,
    input  t_sum                    i_vy,
    input  t_ang                    i_z,
    output logic                    o_valid,
    output logic signed [ROT_W-1:0] o_x,
    output logic signed [ROT_W-1:0] o_y
);

    logic signed [ROT_W-1:0] r_x [1:STEPS];
    logic signed [ROT_W-1:0] r_y [1:STEPS];
    t_ang                    r_z [1:STEPS];
    logic [STEPS:1]          r_v;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS-1:1], i_valid};
        end
    end

    // one micro-rotation per stage, the first on the scaled input
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [ROT_W-1:0] ax, ay, xs, ys;
        t_ang                    az;
        if (k == 0) begin : g_first
            assign ax = ROT_W'(i_vx) <<< ROT_SHIFT;
            assign ay = ROT_W'(i_vy) <<< ROT_SHIFT;
            assign az = i_z;
        end else begin : g_next
            assign ax = r_x[k];
            assign ay = r_y[k];
            assign az = r_z[k];
        end
        always_comb begin
            xs = ax >>> k;
            ys = ay >>> k;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (az >= 0) begin
                    r_x[k+1] <= ax - ys;
                    r_y[k+1] <= ay + xs;
                    r_z[k+1] <= az - atan_q16(k);
                end else begin
                    r_x[k+1] <= ax + ys;
                    r_y[k+1] <= ay - xs;
                    r_z[k+1] <= az + atan_q16(k);
                end
            end
        end
    end

    assign o_x     = r_x[STEPS];
    assign o_y     = r_y[STEPS];
    assign o_valid = r_v[STEPS];

endmodule

@@ rtl/core/line_alignment_offset.sv @@
// line alignment offset
// input channel: i_valid / o_stall carries one item of ten Q16.8 coordinates
// (reference segment, target segment, pivot). output channel: o_valid /
// i_stall carries the translation (o_offset_x, o_offset_y), the folded angle
// o_angle_deg in Q8.8 degrees and o_clipped when an offset saturated.
// an item is taken on an edge with valid high and stall low.
// throughput: one item per cycle while o_stall is low, fully pipelined.
// pipeline: 2*CORDIC_STEPS + 6 register stages, in order:
// an input stage, the pre-turn plus one stage per step of the
// vectoring cordic, the fold stage, one stage per step of the rotating
// cordic, two gain multiplier stages and the output register.
// when the receiver stalls the output register holds its item and one more
// item drops into a skid register; o_stall is that skid being full, so the
// whole pipe then freezes and nothing is lost or repeated.
// reset (synchronous, active low) clears all valid bits; no state else.
module line_alignment_offset import lao_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [IN_W-1:0]      i_ref_ax,
    input  logic signed [IN_W-1:0]      i_ref_ay,
    input  logic signed [IN_W-1:0]      i_ref_bx,
    input  logic signed [IN_W-1:0]      i_ref_by,
    input  logic signed [IN_W-1:0]      i_target_ax,
    input  logic signed [IN_W-1:0]      i_target_ay,
    input  logic signed [IN_W-1:0]      i_target_bx,
    input  logic signed [IN_W-1:0]      i_target_by,
    input  logic signed [IN_W-1:0]      i_pivot_x,
    input  logic signed [IN_W-1:0]      i_pivot_y,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [IN_W-1:0]      o_offset_x,
    output logic signed [IN_W-1:0]      o_offset_y,
    output logic signed [ANG_OUT_W-1:0] o_angle_deg,
    output logic                        o_clipped
);

    localparam logic signed [FIN_W-1:0] SAT_HI =
        FIN_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [FIN_W-1:0] SAT_LO = -SAT_HI - FIN_W'(1);

    logic en;

    // skid full freezes the pipe
    logic r_skd_valid;
    assign en      = !r_skd_valid;
    assign o_stall = r_skd_valid;

    // input stage: differences and midpoint terms
    logic                    r_v1;
    logic signed [DIF_W-1:0] r_dxr, r_dyr, r_dxt, r_dyt;
    t_sb_vec                 r_sb1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dxr    <= DIF_W'(i_ref_bx) - DIF_W'(i_ref_ax);
            r_dyr    <= DIF_W'(i_ref_by) - DIF_W'(i_ref_ay);
            r_dxt    <= DIF_W'(i_target_bx) - DIF_W'(i_target_ax);
            r_dyt    <= DIF_W'(i_target_by) - DIF_W'(i_target_ay);
            r_sb1.cx <= SUM_W'(i_target_ax) + SUM_W'(i_target_bx)
                        - (SUM_W'(i_pivot_x) <<< 1);
            r_sb1.cy <= SUM_W'(i_target_ay) + SUM_W'(i_target_by)
                        - (SUM_W'(i_pivot_y) <<< 1);
            r_sb1.vx <= (SUM_W'(i_pivot_x) <<< 1)
                        - (SUM_W'(i_ref_ax) + SUM_W'(i_ref_bx));
            r_sb1.vy <= (SUM_W'(i_pivot_y) <<< 1)
                        - (SUM_W'(i_ref_ay) + SUM_W'(i_ref_by));
        end
    end

    // both line directions
    logic vr_valid, vt_valid;
    t_ang z_ref, z_tgt;

    lao_vec #(.STEPS(CORDIC_STEPS)) u_vec_ref (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_dx    (r_dxr),
        .i_dy    (r_dyr),
        .o_valid (vr_valid),
        .o_z     (z_ref)
    );

    lao_vec #(.STEPS(CORDIC_STEPS)) u_vec_tgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_dx    (r_dxt),
        .i_dy    (r_dyt),
        .o_valid (vt_valid),
        .o_z     (z_tgt)
    );

    // sideband delay beside the vectoring pipe
    t_sb_vec r_sbv [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sbv[0] <= r_sb1;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_sbv[k] <= r_sbv[k-1];
            end
        end
    end

    // angle difference folded into -90..+90
    logic signed [FOLD_W-1:0] s0, s1, s2;

    always_comb begin
        s0 = FOLD_W'(z_ref) - FOLD_W'(z_tgt);
        s1 = s0;
        if (s0 > DEG90) begin
            s1 = s0 - DEG180;
        end else if (s0 < -DEG90) begin
            s1 = s0 + DEG180;
        end
        s2 = s1;
        if (s1 > DEG90) begin
            s2 = s1 - DEG180;
        end else if (s1 < -DEG90) begin
            s2 = s1 + DEG180;
        end
    end

    logic    r_vf;
    t_ang    r_s;
    t_sb_vec r_sbf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (en) begin
            r_vf <= vr_valid & vt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s   <= ANG_W'(s2);
            r_sbf <= r_sbv[CORDIC_STEPS];
        end
    end

    // pivot vector turned back by the angle
    logic                    rot_valid;
    logic signed [ROT_W-1:0] rot_x, rot_y;

    lao_rot #(.STEPS(CORDIC_STEPS)) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vf),
        .i_vx    (r_sbf.vx),
        .i_vy    (r_sbf.vy),
        .i_z     (-r_s),
        .o_valid (rot_valid),
        .o_x     (rot_x),
        .o_y     (rot_y)
    );

    t_sb_rot r_sbr [1:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sbr[1] <= '{cx: r_sbf.cx, cy: r_sbf.cy, s: r_s};
            for (int k = 2; k <= CORDIC_STEPS; k++) begin
                r_sbr[k] <= r_sbr[k-1];
            end
        end
    end

    // gain correction, partial products
    logic                   r_vm;
    logic signed [PP_W-1:0] r_plx, r_phx, r_ply, r_phy;
    t_sb_rot                r_sbm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (en) begin
            r_vm <= rot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plx <= PP_W'($signed({1'b0, rot_x[MUL_SPLIT-1:0]}) * GAIN_Q24);
            r_phx <= PP_W'($signed(rot_x[ROT_W-1:MUL_SPLIT]) * GAIN_Q24);
            r_ply <= PP_W'($signed({1'b0, rot_y[MUL_SPLIT-1:0]}) * GAIN_Q24);
            r_phy <= PP_W'($signed(rot_y[ROT_W-1:MUL_SPLIT]) * GAIN_Q24);
            r_sbm <= r_sbr[CORDIC_STEPS];
        end
    end

    // gain correction, sum and floor
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic                     r_vg;
    logic signed [GR_W-1:0]   r_gx, r_gy;
    t_sb_rot                  r_sbg;

    always_comb begin
        prod_x = (PROD_W'(r_phx) <<< MUL_SPLIT) + PROD_W'(r_plx);
        prod_y = (PROD_W'(r_phy) <<< MUL_SPLIT) + PROD_W'(r_ply);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vg <= 1'b0;
        end else if (en) begin
            r_vg <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gx  <= GR_W'(prod_x >>> GAIN_SHIFT);
            r_gy  <= GR_W'(prod_y >>> GAIN_SHIFT);
            r_sbg <= r_sbm;
        end
    end

    // offset rounding and saturation
    logic signed [FIN_W-1:0] fx, fy;
    logic signed [IN_W-1:0]  n_ox, n_oy;
    logic signed [ANG_W-1:0] ang_r;
    logic signed [ANG_OUT_W-1:0] n_ang;
    logic                    n_clip;

    always_comb begin
        fx = ((FIN_W'(r_sbg.cx) <<< ROT_SHIFT) + FIN_W'(r_gx) + FIN_W'(256)) >>> 9;
        fy = ((FIN_W'(r_sbg.cy) <<< ROT_SHIFT) + FIN_W'(r_gy) + FIN_W'(256)) >>> 9;
        n_clip = 1'b0;
        if (fx > SAT_HI) begin
            fx = SAT_HI;
            n_clip = 1'b1;
        end else if (fx < SAT_LO) begin
            fx = SAT_LO;
            n_clip = 1'b1;
        end
        if (fy > SAT_HI) begin
            fy = SAT_HI;
            n_clip = 1'b1;
        end else if (fy < SAT_LO) begin
            fy = SAT_LO;
            n_clip = 1'b1;
        end
        n_ox  = fx[IN_W-1:0];
        n_oy  = fy[IN_W-1:0];
        ang_r = (r_sbg.s + ANG_RND) >>> 8;
        n_ang = ang_r[ANG_OUT_W-1:0];
    end

    // output register and skid
    logic                        r_out_valid;
    logic signed [IN_W-1:0]      r_ox, r_oy, r_sx, r_sy;
    logic signed [ANG_OUT_W-1:0] r_oa, r_sa;
    logic                        r_oc, r_sc;
    logic                        take, arrive;

    assign take   = r_out_valid && !i_stall;
    assign arrive = en && r_vg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (!r_out_valid || take) begin
                r_out_valid <= r_skd_valid || arrive;
                r_skd_valid <= 1'b0;
            end else if (arrive) begin
                r_skd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skd_valid) begin
                r_ox <= r_sx;
                r_oy <= r_sy;
                r_oa <= r_sa;
                r_oc <= r_sc;
            end else begin
                r_ox <= n_ox;
                r_oy <= n_oy;
                r_oa <= n_ang;
                r_oc <= n_clip;
            end
        end else if (arrive) begin
            r_sx <= n_ox;
            r_sy <= n_oy;
            r_sa <= n_ang;
            r_sc <= n_clip;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_offset_x  = r_ox;
    assign o_offset_y  = r_oy;
    assign o_angle_deg = r_oa;
    assign o_clipped   = r_oc;

endmodule

@@ rtl/core/lao_checker.sv @@
`include "line_alignment_offset_defines.svh"

module lao_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_stall,
    input logic        o_valid,
    input logic [23:0] o_offset_x,
    input logic [15:0] o_angle_deg
);

    // a stalled item holds
    `LAO_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_offset_x) && $stable(o_angle_deg), "stalled item changed")

    // the skid only fills behind a full output
    `LAO_ASSERT_NOW(a_skid, i_clk, i_rst_n, o_stall, o_valid, "input stalled with no item on the output")

    // a taken item drains the skid
    `LAO_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_stall && !i_stall, !o_stall, "skid did not drain")

    // angle stays folded
    `LAO_ASSERT_NOW(a_fold, i_clk, i_rst_n, o_valid, ($signed(o_angle_deg) <= 16'sd23040) && ($signed(o_angle_deg) >= -16'sd23040), "angle out of range")

endmodule

bind line_alignment_offset lao_checker u_lao_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .o_offset_x  (o_offset_x),
    .o_angle_deg (o_angle_deg)
);
